// ----- design/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// pba_pkg: shared definitions for the page bitmap allocator
// Field widths, command codes and status codes used across the design.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int CMD_W    = 2;
    localparam int START_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 12;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [START_W-1:0]  page_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_ALLOC   = 2'd0;
    localparam cmd_t CMD_FREE    = 2'd1;
    localparam cmd_t CMD_RESERVE = 2'd2;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_NO_SPACE   = 2'd1;
    localparam status_t ST_ZERO_COUNT = 2'd2;

endpackage

// ----- design/pba_req_if.sv -----
// ----------------------------------------------------------------------------
// pba_req_if: command channel
// Carries one allocator command per transfer with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pba_req_if import pba_pkg::*; ();
    logic   valid;
    logic   ready;
    cmd_t   cmd;
    page_t  start_page;
    count_t page_count;

    modport source (output valid, output cmd, output start_page, output page_count,
                    input ready);
    modport sink   (input valid, input cmd, input start_page, input page_count,
                    output ready);
endinterface

// ----- design/pba_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pba_rsp_if: result channel
// Carries one allocator result per transfer with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pba_rsp_if import pba_pkg::*; ();
    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [FOUND_W-1:0]   found_page;

    modport source (output valid, output status, output found_page, input ready);
    modport sink   (input valid, input status, input found_page, output ready);
endinterface

// ----- design/pba_bitmap_mem.sv -----
// ----------------------------------------------------------------------------
// pba_bitmap_mem: page bitmap storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pba_bitmap_mem #(
    parameter int WORDS = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/pba_seg_unit.sv -----
// ----------------------------------------------------------------------------
// pba_seg_unit: free segment finder
// From a bit position in a bitmap word, measures the free stretch that starts
// there and locates the next free bit after the used stretch that ends it.
// ----------------------------------------------------------------------------
module pba_seg_unit #(
    parameter int PPW = 32,
    parameter int BW  = 5,
    parameter int LW  = 6
) (
    input  logic [PPW-1:0] word,
    input  logic [BW-1:0]  pos,
    output logic [LW-1:0]  len,
    output logic           has_used,
    output logic           has_free,
    output logic [BW-1:0]  next_free
);

    logic [PPW-1:0] used_hi;
    logic [PPW-1:0] free_hi;
    logic [BW-1:0]  used_pos;

    always_comb
    begin
        used_hi  = word & ({PPW{1'b1}} << pos);
        used_pos = '0;
        for (int i = PPW - 1; i >= 0; i--)
        begin
            if (used_hi[i])
            begin
                used_pos = BW'(i);
            end
        end
        has_used = |used_hi;
        len      = has_used ? (LW'(used_pos) - LW'(pos)) : (LW'(PPW) - LW'(pos));
    end

    always_comb
    begin
        free_hi   = ~word & ({PPW{1'b1}} << used_pos);
        next_free = '0;
        for (int i = PPW - 1; i >= 0; i--)
        begin
            if (free_hi[i])
            begin
                next_free = BW'(i);
            end
        end
        has_free = has_used && (|free_hi);
    end

endmodule

// ----- design/pba_div.sv -----
// ----------------------------------------------------------------------------
// pba_div: start page splitter
// Splits a page index into the word index and the bit offset inside the word
// with a shift and a mask. The word size is a power of two. The result is
// registered and is ready in the cycle after start.
// ----------------------------------------------------------------------------
module pba_div import pba_pkg::*; #(
    parameter int DIVISOR = 32,
    parameter int BW      = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  page_t         dividend,
    output logic          done,
    output page_t         quot,
    output logic [BW-1:0] rem
);

    logic            done_reg;
    logic            done_next;
    page_t           quot_reg;
    page_t           quot_next;
    logic [BW-1:0]   rem_reg;
    logic [BW-1:0]   rem_next;

    always_comb
    begin
        done_next = start;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            quot_next = dividend >> BW;
            rem_next  = BW'(dividend & page_t'(DIVISOR - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ----- design/page_bitmap_first_fit_allocator_core.sv -----
// ----------------------------------------------------------------------------
// page_bitmap_first_fit_allocator_core: first-fit page allocator
// Keeps one bit per page and serves allocate, free and reserve commands.
// ----------------------------------------------------------------------------
// After reset the block clears the bitmap, one word a cycle, and takes no
// command until the clear is done. It works on one command at a time through
// a single-read, single-write bitmap memory. An allocate scans the bitmap
// word by word, stretch by free stretch, and then marks the words that the
// found run covers. Free and reserve first split the start page into word
// and bit with a shift and a mask and then mark the words of the range. A
// zero count or an unused command answers without touching the bitmap. A
// new command is taken while the previous result still waits on the result
// channel.
module page_bitmap_first_fit_allocator_core import pba_pkg::*; #(
    parameter int BITMAP_WORDS   = 128,
    parameter int PAGES_PER_WORD = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    pba_req_if.sink    req,
    pba_rsp_if.source  rsp
);

    localparam int TOTAL_PAGES = BITMAP_WORDS * PAGES_PER_WORD;
    localparam int WAW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int BW  = $clog2(PAGES_PER_WORD);
    localparam int LW  = $clog2(PAGES_PER_WORD + 1);
    localparam int PIW = $clog2(TOTAL_PAGES);
    localparam logic [WAW-1:0] LAST_W = WAW'(BITMAP_WORDS - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_MARK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic                used_reg;
    logic                used_next;
    count_t              cnt_reg;
    count_t              cnt_next;
    count_t              run_reg;
    count_t              run_next;
    logic [WAW-1:0]      w_reg;
    logic [WAW-1:0]      w_next;
    logic [BW-1:0]       b_reg;
    logic [BW-1:0]       b_next;
    logic [PIW-1:0]      base_reg;
    logic [PIW-1:0]      base_next;
    logic [WAW-1:0]      rs_w_reg;
    logic [WAW-1:0]      rs_w_next;
    logic [BW-1:0]       rs_b_reg;
    logic [BW-1:0]       rs_b_next;
    logic [PIW-1:0]      rs_page_reg;
    logic [PIW-1:0]      rs_page_next;
    logic [WAW-1:0]      mw_reg;
    logic [WAW-1:0]      mw_next;
    logic [BW-1:0]       lo_reg;
    logic [BW-1:0]       lo_next;
    count_t              left_reg;
    count_t              left_next;
    status_t             st_reg;
    status_t             st_next;
    logic [FOUND_W-1:0]  fp_reg;
    logic [FOUND_W-1:0]  fp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    status_t             rsp_status_reg;
    status_t             rsp_status_next;
    logic [FOUND_W-1:0]  rsp_found_reg;
    logic [FOUND_W-1:0]  rsp_found_next;

    logic                   accept;
    logic                   mem_wr_en;
    logic [PAGES_PER_WORD-1:0] mem_wr_data;
    logic                   mem_rd_en;
    logic [WAW-1:0]         mem_rd_addr;
    logic [PAGES_PER_WORD-1:0] mem_q;

    logic [LW-1:0]       seg_len;
    logic                seg_has_used;
    logic                seg_has_free;
    logic [BW-1:0]       seg_next_free;
    logic [COUNT_W:0]    run_sum;
    logic                run_hit;
    logic                run_empty;
    logic [PIW-1:0]      here_page;

    logic                div_start;
    logic                div_done;
    page_t               div_quot;
    logic [BW-1:0]       div_rem;

    logic [LW-1:0]       avail;
    count_t              take_full;
    logic [LW-1:0]       take;
    logic [PAGES_PER_WORD-1:0] mark_mask;
    logic [PAGES_PER_WORD-1:0] mark_word;
    logic                mark_last;
    logic                rsp_load;

    pba_bitmap_mem #(
        .WORDS (BITMAP_WORDS),
        .WIDTH (PAGES_PER_WORD),
        .AW    (WAW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mw_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_q)
    );

    pba_seg_unit #(
        .PPW (PAGES_PER_WORD),
        .BW  (BW),
        .LW  (LW)
    ) u_seg (
        .word      (mem_q),
        .pos       (b_reg),
        .len       (seg_len),
        .has_used  (seg_has_used),
        .has_free  (seg_has_free),
        .next_free (seg_next_free)
    );

    pba_div #(
        .DIVISOR (PAGES_PER_WORD),
        .BW      (BW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.start_page),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign accept         = req.valid && req.ready;
    assign div_start      = accept && (req.page_count != '0)
                            && ((req.cmd == CMD_FREE) || (req.cmd == CMD_RESERVE));

    assign run_sum   = (COUNT_W + 1)'(run_reg) + (COUNT_W + 1)'(seg_len);
    assign run_hit   = run_sum >= (COUNT_W + 1)'(cnt_reg);
    assign run_empty = (run_reg == '0);
    assign here_page = base_reg + PIW'(b_reg);

    assign avail     = LW'(PAGES_PER_WORD) - LW'(lo_reg);
    assign take_full = (left_reg < COUNT_W'(avail)) ? left_reg : COUNT_W'(avail);
    assign take      = LW'(take_full);
    assign mark_mask = ({PAGES_PER_WORD{1'b1}} >> (LW'(PAGES_PER_WORD) - take)) << lo_reg;
    assign mark_word = used_reg ? (mem_q | mark_mask) : (mem_q & ~mark_mask);
    assign mark_last = (left_reg == take_full) || (mw_reg == LAST_W);

    assign mem_wr_en   = (state_reg == S_CLR) || (state_reg == S_MARK);
    assign mem_wr_data = (state_reg == S_CLR) ? '0 : mark_word;
    assign rsp_load    = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        cnt_next     = cnt_reg;
        run_next     = run_reg;
        w_next       = w_reg;
        b_next       = b_reg;
        base_next    = base_reg;
        rs_w_next    = rs_w_reg;
        rs_b_next    = rs_b_reg;
        rs_page_next = rs_page_reg;
        mw_next      = mw_reg;
        lo_next      = lo_reg;
        left_next    = left_reg;
        st_next      = st_reg;
        fp_next      = fp_reg;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = '0;
        case (state_reg)
            S_CLR:
            begin
                if (mw_reg == LAST_W)
                begin
                    mw_next    = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    mw_next = mw_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next  = req.page_count;
                    used_next = (req.cmd != CMD_FREE);
                    st_next   = ST_OK;
                    fp_next   = '0;
                    if (req.page_count == '0)
                    begin
                        st_next    = ST_ZERO_COUNT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        case (req.cmd)
                            CMD_ALLOC:
                            begin
                                w_next      = '0;
                                b_next      = '0;
                                base_next   = '0;
                                run_next    = '0;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                state_next  = S_SCAN;
                            end
                            CMD_FREE, CMD_RESERVE:
                            begin
                                state_next = S_DIV;
                            end
                            default:
                            begin
                                state_next = S_DONE;
                            end
                        endcase
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (32'(div_quot) < BITMAP_WORDS)
                    begin
                        mw_next     = WAW'(div_quot);
                        lo_next     = div_rem;
                        left_next   = cnt_reg;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = WAW'(div_quot);
                        state_next  = S_MARK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (run_hit)
                begin
                    mw_next     = run_empty ? w_reg : rs_w_reg;
                    lo_next     = run_empty ? b_reg : rs_b_reg;
                    fp_next     = FOUND_W'(run_empty ? here_page : rs_page_reg);
                    left_next   = cnt_reg;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = run_empty ? w_reg : rs_w_reg;
                    state_next  = S_MARK;
                end
                else
                begin
                    if (seg_has_used)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next = COUNT_W'(run_sum);
                        if (run_empty)
                        begin
                            rs_w_next    = w_reg;
                            rs_b_next    = b_reg;
                            rs_page_next = here_page;
                        end
                    end
                    if (seg_has_free)
                    begin
                        b_next = seg_next_free;
                    end
                    else if (w_reg == LAST_W)
                    begin
                        st_next    = ST_NO_SPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        w_next      = w_reg + 1'b1;
                        b_next      = '0;
                        base_next   = base_reg + PIW'(PAGES_PER_WORD);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = w_reg + 1'b1;
                    end
                end
            end
            S_MARK:
            begin
                if (mark_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mw_next     = mw_reg + 1'b1;
                    lo_next     = '0;
                    left_next   = left_reg - take_full;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mw_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_found_next  = rsp_found_reg;
        if (rsp_load)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = st_reg;
            rsp_found_next  = fp_reg;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            mw_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mw_reg        <= mw_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        used_reg       <= used_next;
        cnt_reg        <= cnt_next;
        run_reg        <= run_next;
        w_reg          <= w_next;
        b_reg          <= b_next;
        base_reg       <= base_next;
        rs_w_reg       <= rs_w_next;
        rs_b_reg       <= rs_b_next;
        rs_page_reg    <= rs_page_next;
        lo_reg         <= lo_next;
        left_reg       <= left_next;
        st_reg         <= st_next;
        fp_reg         <= fp_next;
        rsp_status_reg <= rsp_status_next;
        rsp_found_reg  <= rsp_found_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.found_page = rsp_found_reg;

`ifndef SYNTHESIS
    // No command may be taken while the bitmap is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !req.ready)
        else $error("command taken during bitmap clear");

    // A partial run seen during the scan is always shorter than the request.
    a_run_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (run_reg < cnt_reg))
        else $error("scan run reached count without a hit");

    // Every marking step still has pages left to touch.
    a_mark_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (left_reg != '0))
        else $error("mark pass running with nothing left");

    // Only a successful result carries a page number.
    a_found_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.found_page == '0))
        else $error("found page set on a failed result");
`endif

endmodule

// ----- tb/pba_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pba_checker: result checker for the page bitmap allocator
// Watches the command and result channels and keeps its own copy of the page
// bitmap. For every command transfer it works out the expected status and
// page and queues them. Every result transfer is compared field by field with
// the oldest queued result.
// ----------------------------------------------------------------------------
module pba_checker import pba_pkg::*; #(
    parameter int BITMAP_WORDS   = 128,
    parameter int PAGES_PER_WORD = 32
) (
    input  logic clk,
    input  logic rst_n,
    pba_req_if   req,
    pba_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int TOTAL_PAGES = BITMAP_WORDS * PAGES_PER_WORD;

    typedef struct packed {
        status_t            status;
        logic [FOUND_W-1:0] found_page;
    } page_result_t;

    bit           page_map [TOTAL_PAGES];
    page_result_t pending_results [$];

    function automatic void mark_range(int first, int count, bit used);
        int last;
        if (first >= TOTAL_PAGES)
            return;
        last = (count > TOTAL_PAGES - first) ? TOTAL_PAGES : first + count;
        for (int p = first; p < last; p++)
            page_map[p] = used;
    endfunction

    function automatic page_result_t apply_page_command(cmd_t c, page_t s, count_t n);
        page_result_t r;
        int           run;
        bit           hit;
        r.status     = ST_OK;
        r.found_page = '0;
        run          = 0;
        hit          = 1'b0;
        if (n == '0)
        begin
            r.status = ST_ZERO_COUNT;
            return r;
        end
        case (c)
            CMD_ALLOC:
            begin
                r.status = ST_NO_SPACE;
                for (int p = 0; p < TOTAL_PAGES && !hit; p++)
                begin
                    run = page_map[p] ? 0 : run + 1;
                    if (run == int'(n))
                    begin
                        mark_range(p + 1 - run, run, 1'b1);
                        r.status     = ST_OK;
                        r.found_page = FOUND_W'(p + 1 - run);
                        hit          = 1'b1;
                    end
                end
            end
            CMD_FREE:    mark_range(int'(s), int'(n), 1'b0);
            CMD_RESERVE: mark_range(int'(s), int'(n), 1'b1);
            default:     ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        page_result_t want;
        if (!rst_n)
        begin
            foreach (page_map[i])
                page_map[i] = 1'b0;
            pending_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result transfer: status %0d found_page %0d",
                           rsp.status, rsp.found_page);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.found_page !== want.found_page)
                    begin
                        $error("found_page mismatch: expected %0d, actual %0d",
                               want.found_page, rsp.found_page);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(
                    apply_page_command(req.cmd, req.start_page, req.page_count));
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the page bitmap first-fit allocator
// Drives a directed set of allocate, free and reserve commands at the edges
// of the page range, then random command mixes with random idle bursts on
// both channels and one long hold on the result side. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import pba_pkg::*;

    localparam int   BITMAP_WORDS   = 128;
    localparam int   PAGES_PER_WORD = 32;
    localparam int   TOTAL_PAGES    = BITMAP_WORDS * PAGES_PER_WORD;
    localparam int   STALL_LIMIT    = 20000;
    localparam int   HOLD_CYCLES    = 500;
    localparam int   DRAIN_CYCLES   = 300;
    localparam cmd_t CMD_UNUSED     = 2'd3;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   quiet_cycles;
    bit   source_idling;
    bit   sink_idling;
    bit   hold_request;

    pba_req_if req_ch ();
    pba_rsp_if rsp_ch ();

    page_bitmap_first_fit_allocator_core #(
        .BITMAP_WORDS   (BITMAP_WORDS),
        .PAGES_PER_WORD (PAGES_PER_WORD)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pba_checker #(
        .BITMAP_WORDS   (BITMAP_WORDS),
        .PAGES_PER_WORD (PAGES_PER_WORD)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
        clk = 1'b0;

    always #6 clk = ~clk;

    task automatic send_command(input cmd_t c, input page_t s, input count_t n);
        if (source_idling && $urandom_range(0, 9) < 3)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= c;
        req_ch.start_page <= s;
        req_ch.page_count <= n;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    function automatic count_t random_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return count_t'($urandom_range(1, 48));
        else if (pick < 95)
            return count_t'($urandom_range(49, 600));
        else if (pick < 98)
            return count_t'($urandom_range(601, TOTAL_PAGES));
        return count_t'($urandom_range(TOTAL_PAGES + 1, 8191));
    endfunction

    task automatic send_random_command(input bit fast_only);
        int     pick;
        page_t  s;
        count_t n;
        pick = fast_only ? $urandom_range(45, 91) : $urandom_range(0, 99);
        s    = page_t'($urandom_range(0, TOTAL_PAGES - 1));
        n    = fast_only ? count_t'($urandom_range(1, 40)) : random_count();
        if (pick < 45)
            send_command(CMD_ALLOC, s, n);
        else if (pick < 47)
            send_command(CMD_FREE, '0, count_t'(TOTAL_PAGES));
        else if (pick < 75)
            send_command(CMD_FREE, s, n);
        else if (pick < 92)
            send_command(CMD_RESERVE, s, n);
        else if (pick < 97)
            send_command(cmd_t'($urandom_range(0, 3)), s, '0);
        else
            send_command(CMD_UNUSED, s, n);
    endtask

    initial
    begin
        bit hold_done;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else if (sink_idling && $urandom_range(0, 9) < 2)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_ALLOC;
        req_ch.start_page = '0;
        req_ch.page_count = '0;
        source_idling     = 1'b1;
        sink_idling       = 1'b1;
        hold_request      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_ALLOC, '0, '0);
        send_command(CMD_FREE, 12'd100, '0);
        send_command(CMD_RESERVE, 12'd4095, '0);
        send_command(CMD_UNUSED, 12'd4095, '0);
        send_command(CMD_UNUSED, 12'd7, 13'd5);
        send_command(CMD_ALLOC, 12'd4095, 13'd1);
        send_command(CMD_ALLOC, '0, count_t'(TOTAL_PAGES));
        send_command(CMD_ALLOC, '0, 13'd8191);
        send_command(CMD_FREE, '0, 13'd8191);
        send_command(CMD_ALLOC, '0, count_t'(TOTAL_PAGES));
        send_command(CMD_ALLOC, '0, 13'd1);
        send_command(CMD_FREE, 12'd4095, 13'd1);
        send_command(CMD_ALLOC, '0, 13'd1);
        send_command(CMD_FREE, '0, count_t'(TOTAL_PAGES));
        send_command(CMD_RESERVE, 12'd4000, 13'd200);
        send_command(CMD_RESERVE, '0, 13'd1);
        send_command(CMD_ALLOC, '0, 13'd3);
        send_command(CMD_ALLOC, '0, 13'd40);
        send_command(CMD_RESERVE, 12'd2048, 13'd1);
        send_command(CMD_ALLOC, '0, 13'd2048);
        send_command(CMD_ALLOC, '0, 13'd1000);
        send_command(CMD_ALLOC, '0, 13'd1100);
        send_command(CMD_FREE, 12'd4095, 13'd8191);
        send_command(CMD_FREE, 12'd2730, 13'd4096);
        send_command(CMD_FREE, '0, count_t'(TOTAL_PAGES));

        repeat (300) send_random_command(1'b0);

        source_idling = 1'b0;
        sink_idling   = 1'b0;
        hold_request  = 1'b1;
        repeat (40) send_random_command(1'b1);

        for (int chunk = 0; chunk < 8; chunk++)
        begin
            source_idling = $urandom_range(0, 1);
            sink_idling   = $urandom_range(0, 1);
            repeat (50) send_random_command(1'b0);
        end

        source_idling = 1'b0;
        sink_idling   = 1'b0;
        repeat (150) send_random_command(1'b0);
        req_ch.valid <= 1'b0;

        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
